>>> rtl/msw_pkg.sv
// Shared definitions of the minimax Bellman sweep: word layouts, codes,
// sizes and the saturating add and margin compare used by the datapath.
// Depends on nothing.
package msw_pkg;

  localparam int NODE_COUNT  = 1024;
  localparam int MAX_ACTIONS = 64;
  localparam int VALUE_BITS  = 32;

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int ACT_W  = $clog2(MAX_ACTIONS);
  localparam int CNT_W  = $clog2(MAX_ACTIONS + 1);
  localparam int EPS_W  = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic signed [VALUE_BITS-1:0] VAL_PINF = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] VAL_MINF = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic signed [VALUE_BITS-1:0] VAL_ZERO = '0;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_TRANS = 2'd1;
  localparam logic [1:0] MODE_EMPTY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TERMINAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPS      = 1'd1;

  typedef struct packed {
    logic [1:0]                   mode;
    logic [NODE_W-1:0]            node;
    logic [NODE_W-1:0]            to_node;
    logic signed [VALUE_BITS-1:0] cost;
    logic                         last_of_action;
    logic                         last_of_node;
  } in_word_t;

  typedef struct packed {
    logic [NODE_W-1:0]            out_node;
    logic signed [VALUE_BITS-1:0] new_value;
    logic [ACT_W-1:0]             best_action;
    logic                         has_action;
  } out_word_t;

  // Infinity-aware add; plus infinity dominates minus infinity.
  function automatic logic signed [VALUE_BITS-1:0] sat_add(
      input logic signed [VALUE_BITS-1:0] a,
      input logic signed [VALUE_BITS-1:0] b);
    logic [VALUE_BITS:0] s;
    s = {a[VALUE_BITS-1], a} + {b[VALUE_BITS-1], b};
    if (a == VAL_PINF || b == VAL_PINF) begin
      return VAL_PINF;
    end else if (a == VAL_MINF || b == VAL_MINF) begin
      return VAL_MINF;
    end else if (s[VALUE_BITS] != s[VALUE_BITS-1]) begin
      return s[VALUE_BITS] ? VAL_MINF : VAL_PINF;
    end
    return s[VALUE_BITS-1:0];
  endfunction

  // True when a undercuts b by more than the margin.
  function automatic logic less_eps(
      input logic signed [VALUE_BITS-1:0] a,
      input logic signed [VALUE_BITS-1:0] b,
      input logic [EPS_W-1:0]             eps);
    logic [VALUE_BITS:0] d;
    d = {b[VALUE_BITS-1], b} - {a[VALUE_BITS-1], a};
    if (b == VAL_PINF) begin
      return a != VAL_PINF;
    end else if (a == VAL_MINF) begin
      return b != VAL_MINF;
    end else if (a == VAL_PINF || b == VAL_MINF) begin
      return 1'b0;
    end else if (a >= b) begin
      return 1'b0;
    end
    return d > {{(VALUE_BITS + 1 - EPS_W){1'b0}}, eps};
  endfunction

endpackage

>>> rtl/msw_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Depends on nothing.
module msw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/minimax_bellman_sweep.sv
// Top level of the minimax Bellman sweep: value store, four-stage datapath
// and output register. Depends on msw_pkg and msw_ram.
//
// The block takes one word per cycle while in_stall is low, loads and
// transitions alike; a node's result runs through the s1, s2, s3 registers
// to the output register. The rate is set by the single read port of the
// value store, serving one transition per cycle; the write port takes loads.
// A load takes effect at the edge that accepts it, so a transition accepted
// on any later edge already reads the new value. The store is not cleared
// after reset; entries must be loaded before a transition reads them.
// in_stall rises only when a node-ending word sits in the last stage while
// the output register holds a result that is itself stalled. Configuration
// writes are always ready and must only be issued while the block is idle.
module minimax_bellman_sweep (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  msw_pkg::in_word_t             in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output msw_pkg::out_word_t            out_word,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [msw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [msw_pkg::EPS_W-1:0]     cfg_data
);
  import msw_pkg::*;

  // Configuration registers.
  logic [NODE_W-1:0] terminal_r;
  logic [EPS_W-1:0]  eps_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      terminal_r <= '0;
      eps_r      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TERMINAL: terminal_r <= cfg_data[NODE_W-1:0];
        CFG_EPS:      eps_r      <= cfg_data;
        default:      ;
      endcase
    end
  end

  // The whole pipeline moves together; it holds only when a result must
  // enter an output register that is full and stalled.
  logic advance;
  logic accept;
  logic emit3;
  out_word_t out_word_r;
  logic      out_valid_r;

  assign advance  = !(emit3 && out_valid_r && out_stall);
  assign in_stall = !advance;
  assign accept   = in_valid && advance;

  // Stage 1: store access. The read data lands in the RAM output register.
  logic signed [VALUE_BITS-1:0] rd_data;

  msw_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (NODE_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (accept && in_word.mode == MODE_LOAD),
    .waddr (in_word.node),
    .wdata (in_word.cost),
    .re    (accept && in_word.mode == MODE_TRANS),
    .raddr (in_word.to_node),
    .rdata (rd_data)
  );

  logic                         s1_valid_r;
  logic                         s1_empty_r;
  logic [NODE_W-1:0]            s1_node_r;
  logic signed [VALUE_BITS-1:0] s1_cost_r;
  logic                         s1_last_act_r;
  logic                         s1_last_node_r;
  logic                         s1_to_term_r;
  logic                         s1_node_term_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= accept && (in_word.mode == MODE_TRANS || in_word.mode == MODE_EMPTY);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_empty_r     <= in_word.mode == MODE_EMPTY;
      s1_node_r      <= in_word.node;
      s1_cost_r      <= in_word.cost;
      s1_last_act_r  <= in_word.last_of_action;
      s1_last_node_r <= in_word.last_of_node;
      s1_to_term_r   <= in_word.to_node == terminal_r;
      s1_node_term_r <= in_word.node == terminal_r;
    end
  end

  // Stage 2: candidate sum of cost and successor value.
  logic                         s2_valid_r;
  logic                         s2_empty_r;
  logic [NODE_W-1:0]            s2_node_r;
  logic signed [VALUE_BITS-1:0] s2_cand_r;
  logic                         s2_close_r;
  logic                         s2_last_node_r;
  logic                         s2_node_term_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_empty_r     <= s1_empty_r;
      s2_node_r      <= s1_node_r;
      s2_cand_r      <= sat_add(s1_cost_r, s1_to_term_r ? VAL_ZERO : rd_data);
      // A node end also closes the action that is open.
      s2_close_r     <= s1_last_act_r || s1_last_node_r;
      s2_last_node_r <= s1_last_node_r;
      s2_node_term_r <= s1_node_term_r;
    end
  end

  // Stage 3: running maximum over the transitions of one action.
  logic signed [VALUE_BITS-1:0] action_max_r;
  logic signed [VALUE_BITS-1:0] action_max_upd;

  assign action_max_upd = (s2_cand_r > action_max_r) ? s2_cand_r : action_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      action_max_r <= VAL_MINF;
    end else if (advance && s2_valid_r) begin
      if (s2_empty_r || s2_close_r) begin
        action_max_r <= VAL_MINF;
      end else begin
        action_max_r <= action_max_upd;
      end
    end
  end

  logic                         s3_valid_r;
  logic                         s3_empty_r;
  logic [NODE_W-1:0]            s3_node_r;
  logic signed [VALUE_BITS-1:0] s3_value_r;
  logic                         s3_end_node_r;
  logic                         s3_node_term_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (advance) begin
      // Only closed actions and empty markers reach the node stage.
      s3_valid_r <= s2_valid_r && (s2_empty_r || s2_close_r);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_empty_r     <= s2_empty_r;
      s3_node_r      <= s2_node_r;
      s3_value_r     <= action_max_upd;
      s3_end_node_r  <= s2_last_node_r;
      s3_node_term_r <= s2_node_term_r;
    end
  end

  // Stage 4: running minimum over the actions of the node.
  logic signed [VALUE_BITS-1:0] node_min_r;
  logic [ACT_W-1:0]             best_index_r;
  logic                         best_valid_r;
  logic [CNT_W-1:0]             action_count_r;

  logic                         cnt_ok;
  logic                         take;
  logic                         close4;
  logic signed [VALUE_BITS-1:0] min_upd;
  logic [ACT_W-1:0]             idx_upd;
  logic                         bv_upd;
  out_word_t                    result;

  assign cnt_ok = action_count_r < CNT_W'(MAX_ACTIONS);
  assign close4 = s3_valid_r && !s3_empty_r;
  assign take   = close4 && cnt_ok && less_eps(s3_value_r, node_min_r, eps_r);
  assign emit3  = s3_valid_r && (s3_empty_r || s3_end_node_r);

  assign min_upd = take ? s3_value_r : node_min_r;
  assign idx_upd = take ? action_count_r[ACT_W-1:0] : best_index_r;
  assign bv_upd  = take || best_valid_r;

  always_comb begin
    result.out_node    = s3_node_r;
    result.new_value   = min_upd;
    result.best_action = bv_upd ? idx_upd : '0;
    result.has_action  = bv_upd;
    if (s3_empty_r) begin
      result.new_value   = s3_node_term_r ? VAL_ZERO : VAL_PINF;
      result.best_action = '0;
      result.has_action  = 1'b0;
    end else if (s3_node_term_r) begin
      // The terminal node reports zero whatever its transitions gave.
      result.new_value   = VAL_ZERO;
      result.best_action = '0;
      result.has_action  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_min_r     <= VAL_PINF;
      best_index_r   <= '0;
      best_valid_r   <= 1'b0;
      action_count_r <= '0;
    end else if (advance && s3_valid_r) begin
      if (emit3) begin
        node_min_r     <= VAL_PINF;
        best_index_r   <= '0;
        best_valid_r   <= 1'b0;
        action_count_r <= '0;
      end else begin
        node_min_r     <= min_upd;
        best_index_r   <= idx_upd;
        best_valid_r   <= bv_upd;
        if (cnt_ok) begin
          action_count_r <= action_count_r + CNT_W'(1);
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit3) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit3) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Checks on the datapath.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && emit3))
    else $error("input stalled without a blocked result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    action_count_r <= CNT_W'(MAX_ACTIONS))
    else $error("action count beyond its limit");

  a_best_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !best_valid_r |-> (best_index_r == '0 && node_min_r == VAL_PINF))
    else $error("best action state set without a valid action");

  a_empty_out: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s3_valid_r && s3_empty_r) |=> (out_valid_r && !out_word_r.has_action))
    else $error("empty marker reported an action");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && emit3) |=> (action_count_r == '0 && !best_valid_r))
    else $error("node state not cleared after a result");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Testbench for minimax_bellman_sweep: directed and random sweeps checked against
// a built-in predictor of the minimax Bellman update. Depends on msw_pkg and the RTL.
module tb;
  import msw_pkg::*;

  // Mode 3 has no meaning in the package; the block must ignore it.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam longint PLUS_INF  = longint'(VAL_PINF);
  localparam longint MINUS_INF = longint'(VAL_MINF);

  // Quiet time after the last owed result, enough for the pipeline to drain
  // before a register write.
  localparam int SETTLE_CYCLES = 8;
  // Cycles without any handshake before the run is declared hung.
  localparam int QUIET_LIMIT   = 2000;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_word_t              in_word   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_word;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [EPS_W-1:0]      cfg_data  = '0;

  minimax_bellman_sweep dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state. It mirrors the block: the old values that loads wrote, the
  // worst sum of the open action, the best action value of the open node, and
  // the two configuration registers.
  // ---------------------------------------------------------------------------
  longint             old_value_mem [NODE_COUNT];
  bit                 loaded_map [NODE_COUNT];
  int                 loaded_nodes [$];
  longint             action_worst;
  longint             node_best;
  logic [ACT_W-1:0]   best_action_idx;
  bit                 best_seen;
  int                 actions_closed;
  logic [NODE_W-1:0]  terminal_id = '0;
  logic [EPS_W-1:0]   margin      = '0;

  // Node results still owed by the block, oldest first.
  out_word_t          node_results_q [$];

  int                 mismatches   = 0;
  int                 words_sent   = 0;
  int                 quiet_cycles = 0;
  bit                 calm_run     = 1'b0;
  out_word_t          want_word;

  // Infinity-aware add: plus infinity wins over minus infinity, and finite
  // sums clip to the infinity codes.
  function automatic longint inf_add(longint a, longint b);
    longint s;
    if (a == PLUS_INF || b == PLUS_INF) return PLUS_INF;
    if (a == MINUS_INF || b == MINUS_INF) return MINUS_INF;
    s = a + b;
    if (s > PLUS_INF) return PLUS_INF;
    if (s < MINUS_INF) return MINUS_INF;
    return s;
  endfunction

  // True when a beats b by more than the margin; equal infinities never beat.
  function automatic bit beats_by_margin(longint a, longint b);
    if (b == PLUS_INF) return a != PLUS_INF;
    if (a == MINUS_INF) return b != MINUS_INF;
    if (a == PLUS_INF || b == MINUS_INF) return 1'b0;
    if (a >= b) return 1'b0;
    return (b - a) > longint'(margin);
  endfunction

  function automatic void open_node();
    action_worst    = MINUS_INF;
    node_best       = PLUS_INF;
    best_action_idx = '0;
    best_seen       = 1'b0;
    actions_closed  = 0;
  endfunction

  // Advances the predictor by one accepted word and queues the result, if any.
  function automatic void bellman_step(in_word_t w);
    longint    succ_value;
    longint    path_cost;
    out_word_t r;
    r = '0;
    case (w.mode)
      MODE_LOAD: begin
        old_value_mem[w.node] = longint'(w.cost);
      end
      MODE_EMPTY: begin
        open_node();
        r.out_node  = w.node;
        r.new_value = (w.node == terminal_id) ? VAL_ZERO : VAL_PINF;
        node_results_q.push_back(r);
      end
      MODE_TRANS: begin
        succ_value = 0;
        if (w.to_node != terminal_id) begin
          succ_value = old_value_mem[w.to_node];
        end
        path_cost = inf_add(longint'(w.cost), succ_value);
        if (path_cost > action_worst) begin
          action_worst = path_cost;
        end
        // The end of a node also closes its open action.
        if (w.last_of_action || w.last_of_node) begin
          if (actions_closed < MAX_ACTIONS) begin
            if (beats_by_margin(action_worst, node_best)) begin
              node_best       = action_worst;
              best_action_idx = actions_closed[ACT_W-1:0];
              best_seen       = 1'b1;
            end
            actions_closed++;
          end
          action_worst = MINUS_INF;
        end
        if (w.last_of_node) begin
          r.out_node = w.node;
          if (w.node != terminal_id) begin
            r.new_value   = node_best[VALUE_BITS-1:0];
            r.best_action = best_seen ? best_action_idx : '0;
            r.has_action  = best_seen;
          end
          node_results_q.push_back(r);
          open_node();
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic in_word_t make_word(logic [1:0] mode, int node, int to_node,
                                         longint cost, bit end_act, bit end_node);
    in_word_t w;
    w.mode           = mode;
    w.node           = node[NODE_W-1:0];
    w.to_node        = to_node[NODE_W-1:0];
    w.cost           = cost[VALUE_BITS-1:0];
    w.last_of_action = end_act;
    w.last_of_node   = end_node;
    return w;
  endfunction

  // Small values most often, so that the margin decides ties, with the infinity
  // codes and values next to them to hit saturation.
  function automatic longint pick_value();
    case ($urandom_range(9))
      3:       return longint'($urandom_range(2000000)) - 1000000;
      4:       return longint'($signed($urandom));
      5:       return PLUS_INF;
      6:       return MINUS_INF;
      7:       return PLUS_INF - longint'($urandom_range(3));
      8:       return MINUS_INF + longint'($urandom_range(3));
      default: return longint'($urandom_range(128)) - 64;
    endcase
  endfunction

  // Successors are either the terminal node or a node that was loaded, so the
  // block never uses a store entry that holds nothing yet.
  function automatic int pick_successor();
    if (loaded_nodes.size() == 0 || $urandom_range(99) < 20) return int'(terminal_id);
    return loaded_nodes[$urandom_range(loaded_nodes.size() - 1)];
  endfunction

  task automatic note_mismatch(string what, longint want, longint got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side. The sender idles at random unless calm_run is set; the word is
  // held until the edge at which in_stall is low, and only then does the
  // predictor see it.
  // ---------------------------------------------------------------------------
  task automatic send_word(in_word_t w);
    while (!calm_run && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bellman_step(w);
    if (w.mode != MODE_SPARE) words_sent++;
  endtask

  task automatic load_value(int node, longint value);
    send_word(make_word(MODE_LOAD, node, $urandom_range(NODE_COUNT - 1), value,
                        1'($urandom_range(1)), 1'($urandom_range(1))));
    if (!loaded_map[NODE_W'(node)]) begin
      loaded_map[NODE_W'(node)] = 1'b1;
      loaded_nodes.push_back(node);
    end
  endtask

  // Drops in_valid, waits for every owed result, then lets the pipeline drain
  // words that produce no result.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (node_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes; cfg_valid is lowered once by the caller so that two
  // writes in a row never assign it twice in one step.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [EPS_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_TERMINAL) begin
      terminal_id = data[NODE_W-1:0];
    end else begin
      margin = data;
    end
  endtask

  // The terminal register keeps only its low bits; the upper ones are random.
  task automatic configure(int term, logic [EPS_W-1:0] eps);
    write_reg(CFG_TERMINAL, {6'($urandom_range(63)), term[NODE_W-1:0]});
    write_reg(CFG_EPS, eps);
    cfg_valid <= 1'b0;
  endtask

  // One random node: mostly a well-formed group of actions with random
  // content, sometimes a marker, noise, a load, or a node cut short.
  task automatic send_random_node();
    int node;
    int n_act;
    int n_tr;
    int roll;
    bit end_act;
    bit end_node;
    node = ($urandom_range(99) < 15) ? int'(terminal_id) : $urandom_range(NODE_COUNT - 1);
    roll = $urandom_range(99);
    if (roll < 8) begin
      send_word(make_word(MODE_EMPTY, node, $urandom_range(NODE_COUNT - 1), pick_value(),
                          1'($urandom_range(1)), 1'($urandom_range(1))));
    end else if (roll < 12) begin
      send_word(make_word(MODE_SPARE, node, $urandom_range(NODE_COUNT - 1), pick_value(),
                          1'($urandom_range(1)), 1'($urandom_range(1))));
    end else if (roll < 24) begin
      load_value($urandom_range(NODE_COUNT - 1), pick_value());
    end else begin
      n_act = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
      for (int a = 0; a < n_act; a++) begin
        n_tr = $urandom_range(1, 3);
        for (int t = 0; t < n_tr; t++) begin
          // Loads may fall between transitions without touching the node.
          if ($urandom_range(99) < 8) begin
            load_value($urandom_range(NODE_COUNT - 1), pick_value());
          end
          end_node = (a == n_act - 1) && (t == n_tr - 1);
          end_act  = (t == n_tr - 1) && (!end_node || $urandom_range(1));
          if (!end_node && $urandom_range(99) < 3) begin
            // Broken node: an empty marker throws away what was gathered.
            send_word(make_word(MODE_EMPTY, node, 0, 0, 1'b0, 1'b0));
            return;
          end
          send_word(make_word(MODE_TRANS, node, pick_successor(), pick_value(),
                              end_act, end_node));
        end
      end
    end
  endtask

  task automatic run_sweep(int n_words);
    int first;
    first = words_sent;
    while (words_sent - first < n_words) send_random_node();
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Test tasks.
  // ---------------------------------------------------------------------------

  // Hand-picked cases: markers, extreme costs, saturation, the margin tie,
  // ignored words, the terminal node ending, a node closing without an action
  // end, a marker inside a node and a minus-infinity result.
  task automatic test_directed();
    configure(0, 16'd2);
    load_value(1023, PLUS_INF);
    load_value(682, MINUS_INF);
    load_value(341, 100);
    load_value(7, -1);
    load_value(9, PLUS_INF - 15);
    send_word(make_word(MODE_EMPTY, 0, 0, 0, 1'b0, 1'b0));
    send_word(make_word(MODE_EMPTY, 1023, 1023, -1, 1'b1, 1'b1));
    // Node 12: action 1 lands within the margin of action 0 and loses the tie,
    // action 2 saturates, action 3 wins with 49.
    send_word(make_word(MODE_TRANS, 12, 341, 10, 1'b1, 1'b0));
    send_word(make_word(MODE_TRANS, 12, 0, 108, 1'b1, 1'b0));
    send_word(make_word(MODE_SPARE, 12, 7, -1, 1'b1, 1'b1));
    send_word(make_word(MODE_TRANS, 12, 9, 100, 1'b1, 1'b0));
    send_word(make_word(MODE_TRANS, 12, 7, 50, 1'b0, 1'b0));
    load_value(341, -200);
    send_word(make_word(MODE_TRANS, 12, 341, MINUS_INF, 1'b1, 1'b1));
    // Every action infinite.
    send_word(make_word(MODE_TRANS, 20, 1023, -5, 1'b1, 1'b0));
    send_word(make_word(MODE_TRANS, 20, 9, PLUS_INF, 1'b1, 1'b1));
    // The terminal node reports zero whatever its transitions say.
    send_word(make_word(MODE_TRANS, 0, 341, 3, 1'b1, 1'b1));
    send_word(make_word(MODE_TRANS, 30, 7, 0, 1'b0, 1'b1));
    send_word(make_word(MODE_TRANS, 40, 341, 1, 1'b1, 1'b0));
    send_word(make_word(MODE_EMPTY, 40, 0, 0, 1'b0, 1'b0));
    send_word(make_word(MODE_TRANS, 50, 682, 5, 1'b1, 1'b1));
    wait_idle();
  endtask

  // Largest terminal index and margin: most small differences become ties.
  task automatic test_high_margin();
    configure(NODE_COUNT - 1, {EPS_W{1'b1}});
    run_sweep(90);
  endtask

  // One node with more actions than the block counts; costs fall with the
  // action index, so the ignored tail would otherwise win.
  task automatic test_action_overflow();
    int node;
    configure($urandom_range(NODE_COUNT - 1), '0);
    node = (terminal_id + 1) % NODE_COUNT;
    for (int a = 0; a < MAX_ACTIONS + 6; a++) begin
      send_word(make_word(MODE_TRANS, node, int'(terminal_id), longint'(1000 - 10 * a), 1'b1,
                          a == MAX_ACTIONS + 5));
    end
    wait_idle();
  endtask

  // A long stretch in which neither side idles, at the full word rate.
  task automatic test_back_to_back();
    configure($urandom_range(NODE_COUNT - 1), EPS_W'($urandom_range(20)));
    calm_run = 1'b1;
    run_sweep(90);
    calm_run = 1'b0;
  endtask

  task automatic test_wide_margin();
    configure(0, EPS_W'($urandom));
    run_sweep(90);
  endtask

  task automatic test_low_margin();
    configure($urandom_range(NODE_COUNT - 1), EPS_W'($urandom_range(4)));
    run_sweep(60);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall, and every accepted result is checked field by
  // field against the oldest owed one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= !calm_run && ($urandom_range(99) < 33);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (node_results_q.size() == 0) begin
        note_mismatch("result with nothing owed, node", -1, longint'(out_word.out_node));
      end else begin
        want_word = node_results_q.pop_front();
        if (out_word.out_node !== want_word.out_node) begin
          note_mismatch("out_node", longint'(want_word.out_node),
                        longint'(out_word.out_node));
        end
        if (out_word.new_value !== want_word.new_value) begin
          note_mismatch("new_value", longint'(want_word.new_value),
                        longint'(out_word.new_value));
        end
        if (out_word.best_action !== want_word.best_action) begin
          note_mismatch("best_action", longint'(want_word.best_action),
                        longint'(out_word.best_action));
        end
        if (out_word.has_action !== want_word.has_action) begin
          note_mismatch("has_action", longint'(want_word.has_action),
                        longint'(out_word.has_action));
        end
      end
    end
  end

  // Watchdog: any handshake on any channel resets the count of quiet cycles.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    open_node();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_high_margin();
    test_action_overflow();
    test_back_to_back();
    test_wide_margin();
    test_low_margin();
    if (mismatches == 0 && node_results_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
